FILE: hw/rtl/direct_mapped_writeback_cache_top_macros.svh
// Assertion macros for the direct-mapped write-back cache
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_TOP_MACROS_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_TOP_MACROS_SVH

// check cons in the same cycle as ante
`define DMWBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define DMWBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/dmwbc_pkg.sv
// Shared constants and types of the direct-mapped write-back cache
`timescale 1ns / 1ps
`default_nettype none

package dmwbc_pkg;

   localparam int LINE_COUNT   = 256;
   localparam int LINE_BYTES   = 64;
   localparam int MEMORY_WORDS = 65536;

   localparam int OP_W    = 2;
   localparam int ADDR_W  = 18;
   localparam int DATA_W  = 32;
   localparam int COST_W  = 10;
   localparam int CSR_DW  = 32;
   localparam int REG_COUNT = 4;
   localparam int REG_IDX_W = $clog2(REG_COUNT);
   localparam int CSR_AW  = REG_IDX_W + 2;

   localparam int LINE_WORDS  = LINE_BYTES / 4;
   localparam int OFS_W       = $clog2(LINE_WORDS);
   localparam int IDX_W       = $clog2(LINE_COUNT);
   localparam int BLK_W       = ADDR_W - 2 - OFS_W;
   localparam int TAG_W       = BLK_W - IDX_W;
   localparam int CACHE_WORDS = LINE_COUNT * LINE_WORDS;
   localparam int CACHE_AW    = IDX_W + OFS_W;
   localparam int MEM_AW      = $clog2(MEMORY_WORDS);
   localparam int CNT_W       = OFS_W + 1;

   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_READ  = 2'd0;
   localparam op_type OP_WRITE = 2'd1;
   localparam op_type OP_CLEAR = 2'd2;

   typedef logic [REG_IDX_W-1:0] reg_idx_type;
   localparam reg_idx_type REG_MEM_READ_COST    = 2'd0;
   localparam reg_idx_type REG_MEM_WRITE_COST   = 2'd1;
   localparam reg_idx_type REG_CACHE_READ_COST  = 2'd2;
   localparam reg_idx_type REG_CACHE_WRITE_COST = 2'd3;

   localparam logic [COST_W-1:0] MEM_READ_COST_RST    = 10'd100;
   localparam logic [COST_W-1:0] MEM_WRITE_COST_RST   = 10'd50;
   localparam logic [COST_W-1:0] CACHE_READ_COST_RST  = 10'd1;
   localparam logic [COST_W-1:0] CACHE_WRITE_COST_RST = 10'd1;

endpackage

`default_nettype wire

FILE: hw/rtl/dmwbc_req_if.sv
// Request channel interface of the direct-mapped write-back cache
`timescale 1ns / 1ps
`default_nettype none

interface dmwbc_req_if;
   logic                         valid;
   logic                         ready;
   logic [dmwbc_pkg::OP_W-1:0]   operation;
   logic [dmwbc_pkg::ADDR_W-1:0] address;
   logic [dmwbc_pkg::DATA_W-1:0] write_word;

   modport source (output valid, output operation, output address, output write_word,
                   input ready);
   modport sink (input valid, input operation, input address, input write_word,
                 output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dmwbc_rsp_if.sv
// Response channel interface of the direct-mapped write-back cache
`timescale 1ns / 1ps
`default_nettype none

interface dmwbc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dmwbc_pkg::DATA_W-1:0] read_word;
   logic                         was_hit;
   logic [dmwbc_pkg::DATA_W-1:0] cost_total;

   modport source (output valid, output read_word, output was_hit, output cost_total,
                   input ready);
   modport sink (input valid, input read_word, input was_hit, input cost_total,
                 output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/direct_mapped_writeback_cache_top.sv
// Top level of the direct-mapped write-back, write-allocate cache
// Direct-mapped write-back, write-allocate cache of 256 lines of 64 bytes over a
// 64K-word backing memory, all held in on-chip memories with one read and one write
// port each. After reset the block zeroes the backing memory, one word a cycle, and
// takes no request meanwhile (CSR writes are taken). One sequencer and one saturating
// cost adder handle each request: a clear or an unused operation code goes from lookup
// to done, a hit from lookup through access to done, a miss on a clean or empty line
// through line fill, reread and access, and a miss on a dirty line through line
// write-back first; the write-back and the fill move one word a cycle. A stalled
// response adds its stall to the request that follows it. A new request is taken
// while the previous response still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "direct_mapped_writeback_cache_top_macros.svh"

module direct_mapped_writeback_cache_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   dmwbc_req_if.sink                              req_ch,
   dmwbc_rsp_if.source                            rsp_ch,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [dmwbc_pkg::CSR_AW-1:0]      csr_paddr,
   input  wire logic [dmwbc_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic      [dmwbc_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                                   csr_pready
);

   typedef enum logic [7:0] {
      ST_INIT   = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_LOOKUP = 8'b0000_0100,
      ST_WBACK  = 8'b0000_1000,
      ST_FILL   = 8'b0001_0000,
      ST_REREAD = 8'b0010_0000,
      ST_ACCESS = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   function automatic logic [dmwbc_pkg::MEM_AW-1:0] mem_slot(
      input logic [dmwbc_pkg::BLK_W-1:0] blk,
      input logic [dmwbc_pkg::OFS_W-1:0] k
   );
      logic [dmwbc_pkg::BLK_W+dmwbc_pkg::OFS_W-1:0] w;
      w = {blk, k};
      return dmwbc_pkg::MEM_AW'(w);
   endfunction

   state_type state_ff, state_in;

   dmwbc_pkg::op_type             op_ff;
   logic [dmwbc_pkg::ADDR_W-1:0]  addr_ff;
   logic [dmwbc_pkg::DATA_W-1:0]  wdata_ff;

   logic [dmwbc_pkg::LINE_COUNT-1:0] valid_ff, valid_in;
   logic [dmwbc_pkg::LINE_COUNT-1:0] dirty_ff, dirty_in;
   logic [dmwbc_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [dmwbc_pkg::MEM_AW-1:0]     clr_ff, clr_in;
   logic [dmwbc_pkg::DATA_W-1:0]     cost_ff, cost_in;
   logic                             hit_ff, hit_in;
   logic [dmwbc_pkg::DATA_W-1:0]     res_word_ff, res_word_in;

   logic [dmwbc_pkg::COST_W-1:0] mem_rd_cost_ff, mem_wr_cost_ff;
   logic [dmwbc_pkg::COST_W-1:0] cache_rd_cost_ff, cache_wr_cost_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [dmwbc_pkg::DATA_W-1:0] rsp_word_ff;
   logic                         rsp_hit_ff;
   logic [dmwbc_pkg::DATA_W-1:0] rsp_cost_ff;
   logic                         rsp_load;

   logic [dmwbc_pkg::TAG_W-1:0]  tag_mem [dmwbc_pkg::LINE_COUNT];
   logic [dmwbc_pkg::TAG_W-1:0]  tag_rd_ff;
   logic                         tag_we;

   logic [dmwbc_pkg::DATA_W-1:0]   cache_mem [dmwbc_pkg::CACHE_WORDS];
   logic [dmwbc_pkg::DATA_W-1:0]   cache_rd_ff;
   logic                           cache_we;
   logic [dmwbc_pkg::CACHE_AW-1:0] cache_waddr, cache_raddr;
   logic [dmwbc_pkg::DATA_W-1:0]   cache_wdata;

   logic [dmwbc_pkg::DATA_W-1:0] back_mem [dmwbc_pkg::MEMORY_WORDS];
   logic [dmwbc_pkg::DATA_W-1:0] back_rd_ff;
   logic                         back_we;
   logic [dmwbc_pkg::MEM_AW-1:0] back_waddr, back_raddr;
   logic [dmwbc_pkg::DATA_W-1:0] back_wdata;

   logic [dmwbc_pkg::COST_W-1:0] addend;
   logic [dmwbc_pkg::DATA_W:0]   cost_sum;
   logic [dmwbc_pkg::DATA_W-1:0] cost_sat;

   logic                          req_accept;
   logic                          csr_write;
   logic [dmwbc_pkg::OFS_W-1:0]   ofs;
   logic [dmwbc_pkg::IDX_W-1:0]   idx;
   logic [dmwbc_pkg::TAG_W-1:0]   tag;
   logic [dmwbc_pkg::BLK_W-1:0]   blk;
   logic [dmwbc_pkg::IDX_W-1:0]   req_idx;
   logic [dmwbc_pkg::OFS_W-1:0]   cnt_k, cnt_k_prev;
   logic                          cnt_done;
   logic                          lookup_hit;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign ofs     = addr_ff[2 +: dmwbc_pkg::OFS_W];
   assign idx     = addr_ff[2 + dmwbc_pkg::OFS_W +: dmwbc_pkg::IDX_W];
   assign tag     = addr_ff[2 + dmwbc_pkg::OFS_W + dmwbc_pkg::IDX_W +: dmwbc_pkg::TAG_W];
   assign blk     = addr_ff[2 + dmwbc_pkg::OFS_W +: dmwbc_pkg::BLK_W];
   assign req_idx = req_ch.address[2 + dmwbc_pkg::OFS_W +: dmwbc_pkg::IDX_W];

   assign cnt_k      = cnt_ff[dmwbc_pkg::OFS_W-1:0];
   assign cnt_k_prev = cnt_k - 1'b1;
   assign cnt_done   = (cnt_ff == dmwbc_pkg::CNT_W'(dmwbc_pkg::LINE_WORDS));
   assign lookup_hit = valid_ff[idx] && (tag_rd_ff == tag);

   assign cost_sum = {1'b0, cost_ff} + (dmwbc_pkg::DATA_W + 1)'(addend);
   assign cost_sat = cost_sum[dmwbc_pkg::DATA_W] ? '1 : cost_sum[dmwbc_pkg::DATA_W-1:0];

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_word  = rsp_word_ff;
   assign rsp_ch.was_hit    = rsp_hit_ff;
   assign rsp_ch.cost_total = rsp_cost_ff;
   assign csr_pready        = 1'b1;

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      dirty_in    = dirty_ff;
      cnt_in      = cnt_ff;
      clr_in      = clr_ff;
      cost_in     = cost_ff;
      hit_in      = hit_ff;
      res_word_in = res_word_ff;
      rsp_load    = 1'b0;
      tag_we      = 1'b0;
      cache_we    = 1'b0;
      cache_waddr = {idx, cnt_k_prev};
      cache_wdata = back_rd_ff;
      cache_raddr = {idx, cnt_k};
      back_we     = 1'b0;
      back_waddr  = mem_slot({tag_rd_ff, idx}, cnt_k_prev);
      back_wdata  = cache_rd_ff;
      back_raddr  = mem_slot(blk, cnt_k);
      addend      = '0;

      case (state_ff)
         ST_INIT: begin
            back_we    = 1'b1;
            back_waddr = clr_ff;
            back_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cache_raddr = {idx, ofs};
            cnt_in      = '0;
            res_word_in = '0;
            if (op_ff inside {dmwbc_pkg::OP_READ, dmwbc_pkg::OP_WRITE}) begin
               hit_in = lookup_hit;
               if (lookup_hit) begin
                  state_in = ST_ACCESS;
               end else if (valid_ff[idx] && dirty_ff[idx]) begin
                  state_in = ST_WBACK;
               end else begin
                  state_in = ST_FILL;
               end
            end else begin
               hit_in   = 1'b0;
               state_in = ST_DONE;
               if (op_ff == dmwbc_pkg::OP_CLEAR) begin
                  cost_in = '0;
               end
            end
         end
         ST_WBACK: begin
            back_we = (cnt_ff != '0);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_done) begin
               addend   = mem_wr_cost_ff;
               cost_in  = cost_sat;
               cnt_in   = '0;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cache_we = (cnt_ff != '0);
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_done) begin
               addend        = mem_rd_cost_ff;
               cost_in       = cost_sat;
               cnt_in        = '0;
               tag_we        = 1'b1;
               valid_in[idx] = 1'b1;
               dirty_in[idx] = 1'b0;
               state_in      = ST_REREAD;
            end
         end
         ST_REREAD: begin
            cache_raddr = {idx, ofs};
            state_in    = ST_ACCESS;
         end
         ST_ACCESS: begin
            if (op_ff == dmwbc_pkg::OP_READ) begin
               res_word_in = cache_rd_ff;
               addend      = cache_rd_cost_ff;
            end else begin
               cache_we      = 1'b1;
               cache_waddr   = {idx, ofs};
               cache_wdata   = wdata_ff;
               dirty_in[idx] = 1'b1;
               addend        = cache_wr_cost_ff;
            end
            cost_in  = cost_sat;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         cost_ff      <= cost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff      <= hit_in;
      res_word_ff <= res_word_in;
      if (req_accept) begin
         op_ff    <= req_ch.operation;
         addr_ff  <= req_ch.address;
         wdata_ff <= req_ch.write_word;
      end
      if (rsp_load) begin
         rsp_word_ff <= res_word_ff;
         rsp_hit_ff  <= hit_ff;
         rsp_cost_ff <= cost_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_rd_cost_ff   <= dmwbc_pkg::MEM_READ_COST_RST;
         mem_wr_cost_ff   <= dmwbc_pkg::MEM_WRITE_COST_RST;
         cache_rd_cost_ff <= dmwbc_pkg::CACHE_READ_COST_RST;
         cache_wr_cost_ff <= dmwbc_pkg::CACHE_WRITE_COST_RST;
      end else if (csr_write) begin
         case (csr_paddr[dmwbc_pkg::CSR_AW-1:2])
            dmwbc_pkg::REG_MEM_READ_COST: begin
               mem_rd_cost_ff <= csr_pwdata[dmwbc_pkg::COST_W-1:0];
            end
            dmwbc_pkg::REG_MEM_WRITE_COST: begin
               mem_wr_cost_ff <= csr_pwdata[dmwbc_pkg::COST_W-1:0];
            end
            dmwbc_pkg::REG_CACHE_READ_COST: begin
               cache_rd_cost_ff <= csr_pwdata[dmwbc_pkg::COST_W-1:0];
            end
            dmwbc_pkg::REG_CACHE_WRITE_COST: begin
               cache_wr_cost_ff <= csr_pwdata[dmwbc_pkg::COST_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[dmwbc_pkg::CSR_AW-1:2])
         dmwbc_pkg::REG_MEM_READ_COST:    csr_prdata = dmwbc_pkg::CSR_DW'(mem_rd_cost_ff);
         dmwbc_pkg::REG_MEM_WRITE_COST:   csr_prdata = dmwbc_pkg::CSR_DW'(mem_wr_cost_ff);
         dmwbc_pkg::REG_CACHE_READ_COST:  csr_prdata = dmwbc_pkg::CSR_DW'(cache_rd_cost_ff);
         dmwbc_pkg::REG_CACHE_WRITE_COST: csr_prdata = dmwbc_pkg::CSR_DW'(cache_wr_cost_ff);
         default:                         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[idx] <= tag;
      end
      if (req_accept) begin
         tag_rd_ff <= tag_mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cache_we) begin
         cache_mem[cache_waddr] <= cache_wdata;
      end
      cache_rd_ff <= cache_mem[cache_raddr];
   end

   always_ff @(posedge clock) begin
      if (back_we) begin
         back_mem[back_waddr] <= back_wdata;
      end
      back_rd_ff <= back_mem[back_raddr];
   end

   `DMWBC_ASSERT_NEXT(a_accept_to_lookup, clock, reset, req_accept,
      state_ff == ST_LOOKUP, "accepted item did not enter lookup")
   `DMWBC_ASSERT_NEXT(a_hit_skips_fill, clock, reset,
      state_ff == ST_LOOKUP && lookup_hit &&
      (op_ff == dmwbc_pkg::OP_READ || op_ff == dmwbc_pkg::OP_WRITE),
      state_ff == ST_ACCESS, "hit did not go straight to access")
   `DMWBC_ASSERT_NEXT(a_done_holds_on_stall, clock, reset,
      state_ff == ST_DONE && rsp_valid_ff && !rsp_ch.ready,
      state_ff == ST_DONE && rsp_valid_ff, "response overwritten while stalled")
   `DMWBC_ASSERT_NOW(a_line_count_range, clock, reset,
      state_ff == ST_WBACK || state_ff == ST_FILL,
      cnt_ff <= dmwbc_pkg::CNT_W'(dmwbc_pkg::LINE_WORDS), "line word count overran")

endmodule

`default_nettype wire

FILE: bench/direct_mapped_writeback_cache_top_tb.sv
// Self-checking testbench of the cache top level: directed and random accesses against a predictor
`timescale 1ns / 1ps

module direct_mapped_writeback_cache_top_tb;
   import dmwbc_pkg::*;

   localparam op_type OP_UNUSED      = 2'd3;
   localparam int     CYCLE_LIMIT    = 1_000_000;
   localparam int     MAX_WAIT       = 13;
   localparam int     DRAIN_CYCLES   = 60;
   localparam int     PHASE_ACCESSES = 235;
   localparam int     PHASE_COUNT    = 6;

   typedef struct packed {
      op_type            operation;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_word;
   } access_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_word;
      logic              was_hit;
      logic [DATA_W-1:0] cost_total;
   } outcome_type;

   logic              clock;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   dmwbc_req_if req_ch();
   dmwbc_rsp_if rsp_ch();

   direct_mapped_writeback_cache_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [COST_W-1:0] fill_cost;
   logic [COST_W-1:0] writeback_cost;
   logic [COST_W-1:0] read_access_cost;
   logic [COST_W-1:0] write_access_cost;
   logic              shadow_valid [LINE_COUNT];
   logic              shadow_dirty [LINE_COUNT];
   logic [TAG_W-1:0]  shadow_tag [LINE_COUNT];
   logic [DATA_W-1:0] shadow_lines [CACHE_WORDS];
   logic [DATA_W-1:0] shadow_memory [MEMORY_WORDS];
   logic [DATA_W-1:0] shadow_cost;

   access_type  pending_accesses[$];
   outcome_type expected_outcomes[$];
   access_type  send_cur;
   outcome_type want;
   int          send_wait;
   int          take_wait;
   int          error_count = 0;
   int          cycle_count = 0;
   bit          steady_flow = 1'b0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic void charge_cost(input logic [COST_W-1:0] amount);
      logic [DATA_W:0] sum;
      sum = {1'b0, shadow_cost} + amount;
      shadow_cost = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
   endfunction

   function automatic outcome_type predict_access(input access_type acc);
      outcome_type      res;
      logic [OFS_W-1:0] ofs;
      logic [IDX_W-1:0] idx;
      logic [TAG_W-1:0] tag;
      res = '0;
      ofs = acc.address[2 +: OFS_W];
      idx = acc.address[2+OFS_W +: IDX_W];
      tag = acc.address[2+OFS_W+IDX_W +: TAG_W];
      if (acc.operation == OP_CLEAR) begin
         shadow_cost = '0;
      end else if (acc.operation == OP_READ || acc.operation == OP_WRITE) begin
         res.was_hit = shadow_valid[idx] && shadow_tag[idx] == tag;
         if (!res.was_hit) begin
            if (shadow_valid[idx] && shadow_dirty[idx]) begin
               for (int k = 0; k < LINE_WORDS; k++)
                  shadow_memory[{shadow_tag[idx], idx, OFS_W'(k)}] =
                     shadow_lines[{idx, OFS_W'(k)}];
               charge_cost(writeback_cost);
            end
            for (int k = 0; k < LINE_WORDS; k++)
               shadow_lines[{idx, OFS_W'(k)}] = shadow_memory[{tag, idx, OFS_W'(k)}];
            charge_cost(fill_cost);
            shadow_valid[idx] = 1'b1;
            shadow_dirty[idx] = 1'b0;
            shadow_tag[idx]   = tag;
         end
         if (acc.operation == OP_READ) begin
            res.read_word = shadow_lines[{idx, ofs}];
            charge_cost(read_access_cost);
         end else begin
            shadow_lines[{idx, ofs}] = acc.write_word;
            shadow_dirty[idx] = 1'b1;
            charge_cost(write_access_cost);
         end
      end
      res.cost_total = shadow_cost;
      return res;
   endfunction

   function automatic int draw_wait();
      if (steady_flow || $urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic access_type random_access();
      access_type acc;
      int         roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         acc.operation = OP_READ;
      else if (roll < 90)
         acc.operation = OP_WRITE;
      else if (roll < 95)
         acc.operation = OP_CLEAR;
      else
         acc.operation = OP_UNUSED;
      if ($urandom_range(0, 4) == 0) begin
         acc.address = ADDR_W'($urandom());
      end else begin
         acc.address = {TAG_W'($urandom_range(0, 3)),
                        IDX_W'($urandom_range(0, 7) + ($urandom_range(0, 1) ? 248 : 0)),
                        OFS_W'($urandom()), 2'($urandom())};
      end
      acc.write_word = $urandom();
      return acc;
   endfunction

   task automatic push_access(input op_type op, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
      access_type acc;
      acc.operation  = op;
      acc.address    = addr;
      acc.write_word = data;
      pending_accesses.push_back(acc);
   endtask

   task automatic write_cost_reg(input reg_idx_type idx, input logic [COST_W-1:0] value);
      logic [CSR_DW-1:0] upper;
      upper = $urandom();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {upper[CSR_DW-1:COST_W], value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_MEM_READ_COST:    fill_cost         = value;
         REG_MEM_WRITE_COST:   writeback_cost    = value;
         REG_CACHE_READ_COST:  read_access_cost  = value;
         REG_CACHE_WRITE_COST: write_access_cost = value;
         default: ;
      endcase
   endtask

   task automatic set_costs(input logic [COST_W-1:0] mem_rd, input logic [COST_W-1:0] mem_wr,
                            input logic [COST_W-1:0] hit_rd, input logic [COST_W-1:0] hit_wr);
      write_cost_reg(REG_MEM_READ_COST, mem_rd);
      write_cost_reg(REG_MEM_WRITE_COST, mem_wr);
      write_cost_reg(REG_CACHE_READ_COST, hit_rd);
      write_cost_reg(REG_CACHE_WRITE_COST, hit_wr);
   endtask

   task automatic await_drain();
      do @(negedge clock);
      while (pending_accesses.size() != 0 || req_ch.valid || expected_outcomes.size() != 0);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_outcomes.push_back(predict_access(send_cur));
         if (!req_ch.valid || req_ch.ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_ch.valid <= 1'b0;
            end else if (pending_accesses.size() != 0) begin
               send_cur = pending_accesses.pop_front();
               req_ch.operation  <= send_cur.operation;
               req_ch.address    <= send_cur.address;
               req_ch.write_word <= send_cur.write_word;
               req_ch.valid      <= 1'b1;
               send_wait = draw_wait();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_wait = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t: unexpected item: read_word %h was_hit %b cost_total %h",
                        $time, rsp_ch.read_word, rsp_ch.was_hit, rsp_ch.cost_total);
               error_count++;
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_ch.read_word !== want.read_word) begin
                  $display("%0t: read_word expected %h actual %h",
                           $time, want.read_word, rsp_ch.read_word);
                  error_count++;
               end
               if (rsp_ch.was_hit !== want.was_hit) begin
                  $display("%0t: was_hit expected %b actual %b",
                           $time, want.was_hit, rsp_ch.was_hit);
                  error_count++;
               end
               if (rsp_ch.cost_total !== want.cost_total) begin
                  $display("%0t: cost_total expected %h actual %h",
                           $time, want.cost_total, rsp_ch.cost_total);
                  error_count++;
               end
            end
            take_wait = draw_wait();
         end else if (rsp_ch.valid && take_wait > 0) begin
            take_wait--;
         end
         rsp_ch.ready <= (take_wait == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("direct_mapped_writeback_cache_top_tb failed");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.operation  = OP_READ;
      req_ch.address    = '0;
      req_ch.write_word = '0;
      rsp_ch.ready      = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      fill_cost         = MEM_READ_COST_RST;
      writeback_cost    = MEM_WRITE_COST_RST;
      read_access_cost  = CACHE_READ_COST_RST;
      write_access_cost = CACHE_WRITE_COST_RST;
      shadow_cost       = '0;
      for (int i = 0; i < LINE_COUNT; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_dirty[i] = 1'b0;
         shadow_tag[i]   = '0;
      end
      for (int i = 0; i < CACHE_WORDS; i++)
         shadow_lines[i] = '0;
      for (int i = 0; i < MEMORY_WORDS; i++)
         shadow_memory[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      push_access(OP_READ,   18'h00000, $urandom());
      push_access(OP_WRITE,  18'h00000, 32'hFFFF_FFFF);
      push_access(OP_READ,   18'h00003, $urandom());
      push_access(OP_WRITE,  18'h3FFFF, 32'hA5A5_A5A5);
      push_access(OP_WRITE,  18'h04000, 32'h5A5A_5A5A);
      push_access(OP_READ,   18'h00000, $urandom());
      push_access(OP_READ,   18'h04000, $urandom());
      push_access(OP_WRITE,  18'h0003C, 32'h0000_0000);
      push_access(OP_UNUSED, 18'h3FFFF, 32'hFFFF_FFFF);
      push_access(OP_READ,   18'h3FFFC, $urandom());
      push_access(OP_CLEAR,  18'h3FFFF, 32'hFFFF_FFFF);
      push_access(OP_WRITE,  18'h3C000, 32'h0F0F_0F0F);
      push_access(OP_READ,   18'h3C000, $urandom());
      push_access(OP_READ,   18'h2AAA8, $urandom());
      push_access(OP_WRITE,  18'h15557, 32'h9696_9696);
      push_access(OP_UNUSED, 18'h00000, 32'h0000_0000);
      push_access(OP_READ,   18'h0003C, $urandom());
      push_access(OP_CLEAR,  18'h00000, 32'h0000_0000);
      await_drain();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: set_costs('0, '0, '0, '0);
            1: set_costs('1, '1, '1, '1);
            2: set_costs(COST_W'($urandom()), COST_W'($urandom()),
                         COST_W'($urandom()), COST_W'($urandom()));
            3: set_costs('1, '0, '1, '0);
            4: set_costs('0, '1, '0, '1);
            default: set_costs(MEM_READ_COST_RST, MEM_WRITE_COST_RST,
                               CACHE_READ_COST_RST, CACHE_WRITE_COST_RST);
         endcase
         steady_flow = ($urandom_range(0, 3) == 0);
         repeat (PHASE_ACCESSES) pending_accesses.push_back(random_access());
         await_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("direct_mapped_writeback_cache_top_tb passed");
      else
         $display("direct_mapped_writeback_cache_top_tb failed");
      $finish;
   end

endmodule
